@@ rtl/euler_to_quaternion_assert.svh @@
// ----------------------------------------------------------------------------
// euler_to_quaternion assertion macros
// concurrent checks, compiled away for synthesis
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH
`ifndef SYNTHESIS
// implication checked on every rising edge outside reset
`define E2Q_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);
// check that also runs during reset
`define E2Q_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);
`else
`define E2Q_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define E2Q_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

@@ rtl/e2q_pkg.sv @@
// ----------------------------------------------------------------------------
// e2q_pkg
// shared widths, arctangent table and output rounding for the converter
// ----------------------------------------------------------------------------
`default_nettype none
package e2q_pkg;
    localparam int ANGLE_BITS     = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int OUT_BITS       = QUAT_FRAC_BITS + 2;
    localparam int CORDIC_STEPS   = 24;
    localparam int INNER_FRAC     = 30;
    localparam int CW             = 34;  // cordic datapath width
    localparam int TW             = 32;  // sine / cosine width
    localparam int PW             = 34;  // pair / triple product width
    localparam int LAT            = CORDIC_STEPS + 4;
    localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;

    typedef logic signed [TW-1:0] trig_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [OUT_BITS-1:0] quat_t;

    // arctangent of 2^-i, pi = 2^32
    function automatic logic signed [CW-1:0] atan_val(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0: r = 34'sd1073741824;  1: r = 34'sd633866812;
            2: r = 34'sd334917814;   3: r = 34'sd170009512;
            4: r = 34'sd85334662;    5: r = 34'sd42708930;
            6: r = 34'sd21359676;    7: r = 34'sd10680490;
            8: r = 34'sd5340326;     9: r = 34'sd2670174;
            10: r = 34'sd1335088;    11: r = 34'sd667544;
            12: r = 34'sd333772;     13: r = 34'sd166886;
            14: r = 34'sd83444;      15: r = 34'sd41722;
            16: r = 34'sd20860;      17: r = 34'sd10430;
            18: r = 34'sd5216;       19: r = 34'sd2608;
            20: r = 34'sd1304;       21: r = 34'sd652;
            22: r = 34'sd326;        23: r = 34'sd162;
            default: r = '0;
        endcase
        return r;
    endfunction

    // round q30 sum to output fraction bits, ties up, clamp to plus or minus one
    function automatic quat_t round_sat(input logic signed [PW:0] s);
        logic signed [PW+1:0] t;
        logic signed [PW+1:0] v;
        logic signed [PW+1:0] one;
        quat_t r;
        one = (PW+2)'(1) <<< QUAT_FRAC_BITS;
        t = (PW+2)'(s) + ((PW+2)'(1) <<< (INNER_FRAC - QUAT_FRAC_BITS - 1));
        v = t >>> (INNER_FRAC - QUAT_FRAC_BITS);
        if (v > one)
            r = OUT_BITS'(one);
        else if (v < -one)
            r = OUT_BITS'(-one);
        else
            r = OUT_BITS'(v);
        return r;
    endfunction
endpackage
`default_nettype wire

@@ rtl/e2q_cordic.sv @@
// ----------------------------------------------------------------------------
// e2q_cordic
// pipelined rotation cordic, one register stage per iteration,
// gives cosine and sine of half the input angle in q30
// ----------------------------------------------------------------------------
`default_nettype none
module e2q_cordic (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [e2q_pkg::ANGLE_BITS-1:0] angle,
    output e2q_pkg::trig_t                           cos_out,
    output e2q_pkg::trig_t                           sin_out
);
    localparam int N  = e2q_pkg::CORDIC_STEPS;
    localparam int CW = e2q_pkg::CW;

    logic signed [CW-1:0] x_reg [N+1];
    logic signed [CW-1:0] y_reg [N+1];
    logic signed [CW-1:0] z_reg [N+1];

    // entry stage: half angle scaled so that pi is 2^32
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= e2q_pkg::CORDIC_START;
            y_reg[0] <= '0;
            z_reg[0] <= CW'(angle) <<< (32 - e2q_pkg::ANGLE_BITS);
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic signed [CW-1:0] x_next, y_next, z_next;
        always_comb
        begin
            if (!z_reg[i][CW-1])
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - e2q_pkg::atan_val(i);
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + e2q_pkg::atan_val(i);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
            end
        end
    end

    assign cos_out = e2q_pkg::TW'(x_reg[N]);
    assign sin_out = e2q_pkg::TW'(y_reg[N]);
endmodule
`default_nettype wire

@@ rtl/e2q_quat_calc.sv @@
// ----------------------------------------------------------------------------
// e2q_quat_calc
// three-stage product pipeline: pair products, triple products, sum and round
// ----------------------------------------------------------------------------
`default_nettype none
module e2q_quat_calc (
    input  wire logic           clk,
    input  wire logic           en,
    input  e2q_pkg::trig_t      cr,
    input  e2q_pkg::trig_t      sr,
    input  e2q_pkg::trig_t      cp,
    input  e2q_pkg::trig_t      sp,
    input  e2q_pkg::trig_t      cy,
    input  e2q_pkg::trig_t      sy,
    output e2q_pkg::quat_t      quat_w,
    output e2q_pkg::quat_t      quat_x,
    output e2q_pkg::quat_t      quat_y,
    output e2q_pkg::quat_t      quat_z
);
    localparam int F = e2q_pkg::INNER_FRAC;
    localparam int PW = e2q_pkg::PW;

    e2q_pkg::prod_t cc_reg, ss_reg, sc_reg, cs_reg;
    e2q_pkg::trig_t cy_reg, sy_reg;
    e2q_pkg::prod_t t_reg [8];
    e2q_pkg::quat_t w_reg, x_reg, y_reg, z_reg;

    logic signed [2*e2q_pkg::TW-1:0] cc_next, ss_next, sc_next, cs_next;
    logic signed [PW+e2q_pkg::TW-1:0] m_next [8];

    // roll and pitch pair products
    always_comb
    begin
        cc_next = cr * cp;
        ss_next = sr * sp;
        sc_next = sr * cp;
        cs_next = cr * sp;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg <= PW'(cc_next >>> F);
            ss_reg <= PW'(ss_next >>> F);
            sc_reg <= PW'(sc_next >>> F);
            cs_reg <= PW'(cs_next >>> F);
            cy_reg <= cy;
            sy_reg <= sy;
        end
    end

    // times yaw terms
    always_comb
    begin
        m_next[0] = cc_reg * cy_reg;
        m_next[1] = ss_reg * sy_reg;
        m_next[2] = sc_reg * cy_reg;
        m_next[3] = cs_reg * sy_reg;
        m_next[4] = cs_reg * cy_reg;
        m_next[5] = sc_reg * sy_reg;
        m_next[6] = cc_reg * sy_reg;
        m_next[7] = ss_reg * cy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 8; k++)
                t_reg[k] <= PW'(m_next[k] >>> F);
        end
    end

    // sum, round and clamp
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg <= e2q_pkg::round_sat((PW+1)'(t_reg[0]) + (PW+1)'(t_reg[1]));
            x_reg <= e2q_pkg::round_sat((PW+1)'(t_reg[2]) - (PW+1)'(t_reg[3]));
            y_reg <= e2q_pkg::round_sat((PW+1)'(t_reg[4]) + (PW+1)'(t_reg[5]));
            z_reg <= e2q_pkg::round_sat((PW+1)'(t_reg[6]) - (PW+1)'(t_reg[7]));
        end
    end

    assign quat_w = w_reg;
    assign quat_x = x_reg;
    assign quat_y = y_reg;
    assign quat_z = z_reg;
endmodule
`default_nettype wire

@@ rtl/euler_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// euler_to_quaternion
// roll, pitch, yaw binary angles to unit attitude quaternion in q1.14
//
//  channel   dir  payload
//  s_axis    in   roll, pitch, yaw (16 bits each)
//  m_axis    out  w, x, y, z (16 bits each)
//
// one transaction per cycle while the output is not stalled; 24 cordic
// stages, entry stage, two multiply stages, sum and round stage
// no state beyond the pipeline; reset clears only the valid bits
// a stall on the output freezes the whole pipeline, s_tready follows
// ----------------------------------------------------------------------------
`default_nettype none
`include "euler_to_quaternion_assert.svh"
module euler_to_quaternion (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // quat_w, quat_x, quat_y, quat_z
);
    localparam int LAT = e2q_pkg::LAT;
    localparam int AB = e2q_pkg::ANGLE_BITS;

    logic [LAT-1:0] valid_reg;
    logic           en;
    e2q_pkg::trig_t cr, sr, cp, sp, cy, sy;
    e2q_pkg::quat_t qw, qx, qy, qz;

    // pipeline advances unless the last stage holds an untaken result
    assign en       = !valid_reg[LAT-1] || m_tready;
    assign s_tready = en;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
    end

    e2q_cordic u_roll (
        .clk(clk), .en(en), .angle(s_tdata[AB-1:0]),
        .cos_out(cr), .sin_out(sr)
    );
    e2q_cordic u_pitch (
        .clk(clk), .en(en), .angle(s_tdata[2*AB-1:AB]),
        .cos_out(cp), .sin_out(sp)
    );
    e2q_cordic u_yaw (
        .clk(clk), .en(en), .angle(s_tdata[3*AB-1:2*AB]),
        .cos_out(cy), .sin_out(sy)
    );

    e2q_quat_calc u_calc (
        .clk(clk), .en(en),
        .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
        .quat_w(qw), .quat_x(qx), .quat_y(qy), .quat_z(qz)
    );

    assign m_tvalid = valid_reg[LAT-1];
    assign m_tdata  = {qz, qy, qx, qw};

    // checks
    `E2Q_ASSERT(a_w_range, clk, rst_n, m_tvalid |-> (qw <= 16'sd16384 && qw >= -16'sd16384), "quat_w out of range")
    `E2Q_ASSERT(a_x_range, clk, rst_n, m_tvalid |-> (qx <= 16'sd16384 && qx >= -16'sd16384), "quat_x out of range")
    `E2Q_ASSERT(a_drop, clk, rst_n, $fell(m_tvalid) |-> $past(m_tready), "result dropped without transaction")
    `E2Q_ASSERT(a_stall, clk, rst_n, (m_tvalid && !m_tready) |=> $stable(valid_reg), "pipeline moved during stall")
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// streams euler angles through the converter and checks every quaternion against a bit-exact
// cordic predictor or a stored known value, with random idling on both sides
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    localparam int N_RANDOM = 800;
    localparam int N_DIRECTED = 12;
    localparam int CORDIC_ONE = 652032874;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } angles_t;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } quat4_t;

    typedef struct {
        angles_t a;
        bit      known;
        quat4_t  q;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // roll_angle, pitch_angle, yaw_angle
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // quat_w, quat_x, quat_y, quat_z

    quat4_t    pending_quats[$];
    stim_row_t angle_table[N_DIRECTED];
    int        n_errors;
    bit        quiet_phase;
    bit        stim_done;

    euler_to_quaternion i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // arithmetic shift, rounds toward minus infinity
    function automatic longint sra(input longint v, input int s);
        return v >>> s;
    endfunction

    // cordic sine and cosine of the half angle
    function automatic void half_trig(input logic signed [15:0] ang,
                                      output longint c, output longint s);
        longint cx;
        longint sy;
        longint acc;
        longint dx;
        longint dy;
        acc = longint'(ang) * 65536;
        cx = CORDIC_ONE;
        sy = 0;
        for (int i = 0; i < e2q_pkg::CORDIC_STEPS; i++)
        begin
            dx = sra(sy, i);
            dy = sra(cx, i);
            if (acc >= 0)
            begin
                cx -= dx; sy += dy; acc -= longint'(e2q_pkg::atan_val(i));
            end
            else
            begin
                cx += dx; sy -= dy; acc += longint'(e2q_pkg::atan_val(i));
            end
        end
        c = cx;
        s = sy;
    endfunction

    function automatic longint tri_mul(input longint a, input longint b, input longint c);
        return sra(sra(a * b, e2q_pkg::INNER_FRAC) * c, e2q_pkg::INNER_FRAC);
    endfunction

    // q30 sum to q1.14 with ties up and clamp to plus or minus one
    function automatic logic signed [15:0] to_q14(input longint sum);
        longint v;
        v = sra(sum + (64'sd1 <<< 15), 16);
        if (v > 16384)
            v = 16384;
        if (v < -16384)
            v = -16384;
        return 16'(v);
    endfunction

    function automatic quat4_t attitude_quat(input angles_t a);
        longint cr, sr, cp, sp, cy, sy;
        quat4_t q;
        half_trig(a.roll, cr, sr);
        half_trig(a.pitch, cp, sp);
        half_trig(a.yaw, cy, sy);
        q.w = to_q14(tri_mul(cr, cp, cy) + tri_mul(sr, sp, sy));
        q.x = to_q14(tri_mul(sr, cp, cy) - tri_mul(cr, sp, sy));
        q.y = to_q14(tri_mul(cr, sp, cy) + tri_mul(sr, cp, sy));
        q.z = to_q14(tri_mul(cr, cp, sy) - tri_mul(sr, sp, cy));
        return q;
    endfunction

    // one transaction in, waits for the handshake
    task automatic send_angles(input angles_t a);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= a;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_quats.push_back(attitude_quat(a));
        @(negedge clk);
    endtask

    // directed rows, zero angles give the identity quaternion
    initial
    begin
        angle_table[0]  = '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd16384}};
        angle_table[1]  = '{'{16'sd0, 16'sd0, -16'sd32768}, 1'b0, '0};
        angle_table[2]  = '{'{16'sd0, 16'sd0, 16'sd32767}, 1'b0, '0};
        angle_table[3]  = '{'{16'sd0, -16'sd32768, 16'sd0}, 1'b0, '0};
        angle_table[4]  = '{'{16'sd0, 16'sd32767, 16'sd0}, 1'b0, '0};
        angle_table[5]  = '{'{-16'sd32768, 16'sd0, 16'sd0}, 1'b0, '0};
        angle_table[6]  = '{'{16'sd32767, 16'sd0, 16'sd0}, 1'b0, '0};
        angle_table[7]  = '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0};
        angle_table[8]  = '{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0};
        angle_table[9]  = '{'{16'sd16384, 16'sd16384, 16'sd16384}, 1'b0, '0};
        angle_table[10] = '{'{-16'sd1, -16'sd1, -16'sd1}, 1'b0, '0};
        angle_table[11] = '{'{16'sd1, -16'sd16384, 16'sd21845}, 1'b0, '0};
    end

    // stimulus
    initial
    begin
        angles_t a;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        quiet_phase = 1'b0;
        stim_done   = 1'b0;
        n_errors    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (angle_table[i])
        begin
            send_angles(angle_table[i].a);
            if (angle_table[i].known)
            begin
                void'(pending_quats.pop_back());
                pending_quats.push_back(angle_table[i].q);
            end
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n > N_RANDOM * 3 / 4)
                quiet_phase = 1'b1;
            a = {16'($urandom), 16'($urandom), 16'($urandom)};
            // some near the wrap points
            if ($urandom_range(0, 7) == 0)
                a.roll = 16'sh8000 + 16'($urandom_range(0, 3));
            send_angles(a);
        end
        s_tvalid  <= 1'b0;
        stim_done = 1'b1;
    end

    // output ready with random stall bursts
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest expected quaternion
    always @(posedge clk)
    begin
        quat4_t exp_q;
        quat4_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_quats.size() == 0)
            begin
                $error("unexpected quaternion %h", m_tdata);
                n_errors++;
            end
            else
            begin
                exp_q = pending_quats.pop_front();
                if (got.w !== exp_q.w)
                begin
                    $error("quat_w expected %0d actual %0d", exp_q.w, got.w);
                    n_errors++;
                end
                if (got.x !== exp_q.x)
                begin
                    $error("quat_x expected %0d actual %0d", exp_q.x, got.x);
                    n_errors++;
                end
                if (got.y !== exp_q.y)
                begin
                    $error("quat_y expected %0d actual %0d", exp_q.y, got.y);
                    n_errors++;
                end
                if (got.z !== exp_q.z)
                begin
                    $error("quat_z expected %0d actual %0d", exp_q.z, got.z);
                    n_errors++;
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (pending_quats.size() != 0)
            @(posedge clk);
        repeat (e2q_pkg::LAT + 10) @(posedge clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
